>>> rtl/tar_archive_entry_parser_top_macros.svh
// Assertion macros shared by the tar entry parser modules.
`ifndef TAR_ARCHIVE_ENTRY_PARSER_TOP_MACROS_SVH
`define TAR_ARCHIVE_ENTRY_PARSER_TOP_MACROS_SVH

// Condition a implies condition c in the same cycle.
`define TAEP_ASSERT_NOW(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// Condition a implies condition c in the following cycle.
`define TAEP_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> rtl/taep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taep_pkg
// Types and constants of the tar archive entry parser.
// ----------------------------------------------------------------------------
package taep_pkg;

  localparam logic [1:0] KIND_CHUNK    = 2'd0;
  localparam logic [1:0] KIND_RECORD   = 2'd1;
  localparam logic [1:0] KIND_FINISHED = 2'd2;

  localparam logic [8:0] HDR_LAST      = 9'd511;
  localparam logic [8:0] NAME_END      = 9'd100;
  localparam logic [8:0] SIZE_START    = 9'd124;
  localparam logic [8:0] SIZE_END      = 9'd136;
  localparam logic [8:0] TYPEFLAG_POS  = 9'd156;
  localparam logic [8:0] MAGIC_START   = 9'd257;
  localparam logic [8:0] MAGIC_END     = 9'd262;
  localparam logic [8:0] PREFIX_START  = 9'd345;
  localparam logic [8:0] PREFIX_END    = 9'd500;
  localparam int         NAME_DEPTH    = 100;
  localparam int         PREFIX_DEPTH  = 155;

  localparam logic [7:0] CHAR_SLASH    = 8'h2f;
  localparam logic [7:0] CHAR_DOT      = 8'h2e;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_SEVEN    = 8'h37;
  localparam logic [7:0] CHAR_FIVE     = 8'h35;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       archive_end;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] name_chunk;
    logic [3:0]  chunk_bytes;
    logic [7:0]  entry_index;
    logic        is_directory;
    logic [35:0] entry_size;
    logic [39:0] data_offset;
    logic [7:0]  path_length;
    logic [8:0]  entries_total;
    logic        run_end;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_HEADER, ST_SKIP, ST_STOP, ST_EVAL, ST_SCAN_RD, ST_SCAN_CK, ST_DECIDE,
    ST_LAST_RD, ST_LAST_CK, ST_CH_RD, ST_CH_CK, ST_CH_OUT, ST_REC, ST_DONE, ST_FIN
  } taep_state_t;

  typedef struct packed {
    logic       any_byte;
    logic       hdr_byte;
    logic       skip_byte;
    logic       eval_load;
    logic       scan_step;
    logic       decide;
    logic       last_chk;
    logic       ch_step;
    logic       ch_clear;
    logic       emit;
    logic [1:0] emit_kind;
    logic       emit_end;
    logic       count_up;
    logic       done;
    logic       reset_all;
  } taep_cmd_t;

  typedef struct packed {
    logic hpos_last;
    logic bad_hdr;
    logic scan_stop;
    logic n_zero;
    logic table_full;
    logic chunk_done;
    logic r_zero;
    logic skip_one;
    logic size_zero;
    logic out_free;
    logic cbytes_nz;
  } taep_status_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h75;
      3'd1:    c = 8'h73;
      3'd2:    c = 8'h74;
      3'd3:    c = 8'h61;
      default: c = 8'h72;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/taep_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taep_chan_if
// Valid/ready channel carrying one item of a chosen payload type.
// ----------------------------------------------------------------------------
interface taep_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> rtl/taep_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taep_datapath
// Header field capture, name stores, path walk and output register.
// ----------------------------------------------------------------------------
module taep_datapath #(
  parameter int MAX_ENTRIES    = 256,
  parameter int PATH_MAX_CHARS = 255
) (
  input  logic                    clk,
  input  logic                    rst,
  input  taep_pkg::taep_cmd_t     cmd,
  input  logic [7:0]              byte_value,
  input  logic                    out_ready,
  output logic                    out_valid,
  output taep_pkg::out_item_t     out_data,
  output taep_pkg::taep_status_t  status
);
  import taep_pkg::*;

  localparam logic [8:0] MaxEnt  = 9'(MAX_ENTRIES);
  localparam logic [7:0] PathMax = 8'(PATH_MAX_CHARS);

  logic [7:0]  fname_mem [NAME_DEPTH];
  logic [7:0]  prefix_mem [PREFIX_DEPTH];
  logic [7:0]  fname_rd, prefix_rd;
  logic        rd_pref, rd_slash;

  logic [8:0]  hpos;
  logic [6:0]  flen;
  logic [7:0]  plen;
  logic [35:0] size;
  logic        size_stop, tdir, magic_ok;
  logic [39:0] offset;
  logic [8:0]  ecount;
  logic [36:0] skip;
  logic [7:0]  len, q, s, n, r;
  logic        dot, dir;
  logic [63:0] chunk;
  logic [3:0]  cbytes;

  logic [8:0]  ppos, total;
  logic [7:0]  nidx, ch;
  logic        q_next_in;

  assign ppos      = hpos - PREFIX_START;
  assign total     = 9'(plen) + 9'(plen != 8'd0) + 9'(flen);
  assign nidx      = (plen != 8'd0) ? (q - plen - 8'd1) : q;
  assign ch        = rd_slash ? CHAR_SLASH : (rd_pref ? prefix_rd : fname_rd);
  assign q_next_in = (9'(q) + 9'd1) < 9'(len);

  always_ff @(posedge clk) begin
    if (cmd.hdr_byte && hpos < NAME_END && hpos[6:0] == flen && byte_value != 8'd0) begin
      fname_mem[hpos[6:0]] <= byte_value;
    end
    if (cmd.hdr_byte && hpos >= PREFIX_START && hpos < PREFIX_END &&
        ppos[7:0] == plen && byte_value != 8'd0) begin
      prefix_mem[ppos[7:0]] <= byte_value;
    end
    if (nidx < 8'(NAME_DEPTH)) begin
      fname_rd <= fname_mem[nidx[6:0]];
    end
    if (q < 8'(PREFIX_DEPTH)) begin
      prefix_rd <= prefix_mem[q];
    end
    rd_pref  <= (plen != 8'd0) && (q < plen);
    rd_slash <= (plen != 8'd0) && (q == plen);
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_all || cmd.done) begin
      hpos      <= '0;
      flen      <= '0;
      plen      <= '0;
      size      <= '0;
      size_stop <= 1'b0;
      tdir      <= 1'b0;
      magic_ok  <= 1'b1;
    end else if (cmd.hdr_byte) begin
      if (hpos < NAME_END) begin
        if (hpos[6:0] == flen && byte_value != 8'd0) flen <= flen + 7'd1;
      end else if (hpos >= SIZE_START && hpos < SIZE_END) begin
        if (!size_stop) begin
          if (byte_value >= CHAR_ZERO && byte_value <= CHAR_SEVEN) begin
            size <= {size[32:0], 3'b000} + 36'(byte_value[2:0]);
          end else begin
            size_stop <= 1'b1;
          end
        end
      end else if (hpos == TYPEFLAG_POS) begin
        tdir <= (byte_value == CHAR_FIVE);
      end else if (hpos >= MAGIC_START && hpos < MAGIC_END) begin
        if (byte_value != magic_char(3'(hpos - MAGIC_START))) magic_ok <= 1'b0;
      end else if (hpos >= PREFIX_START && hpos < PREFIX_END) begin
        if (ppos[7:0] == plen && byte_value != 8'd0) plen <= plen + 8'd1;
      end
      if (hpos != HDR_LAST) hpos <= hpos + 9'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.reset_all) begin
      offset <= '0;
      ecount <= '0;
      skip   <= '0;
    end else begin
      if (cmd.any_byte) offset <= offset + 40'd1;
      if (cmd.count_up) ecount <= ecount + 9'd1;
      if (cmd.skip_byte && skip != '0) skip <= skip - 37'd1;
      if (cmd.done) skip <= ({1'b0, size} + 37'd511) & ~37'd511;
    end
  end

  // Path walk: strip leading "./" and "/", drop a trailing "/", then gather chunks.
  always_ff @(posedge clk) begin
    if (cmd.eval_load) begin
      len <= (total > 9'(PathMax)) ? PathMax : total[7:0];
      q   <= '0;
      s   <= '0;
      dot <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (ch == CHAR_SLASH) begin
        s   <= q + 8'd1;
        dot <= 1'b0;
      end else if (!dot && ch == CHAR_DOT && q_next_in) begin
        dot <= 1'b1;
      end
      q <= q + 8'd1;
    end
    if (cmd.decide) begin
      n   <= len - s;
      q   <= len - 8'd1;
      dir <= tdir;
    end
    if (cmd.last_chk) begin
      q      <= s;
      chunk  <= '0;
      cbytes <= '0;
      if (ch == CHAR_SLASH) begin
        n   <= n - 8'd1;
        r   <= n - 8'd1;
        dir <= 1'b1;
      end else begin
        r <= n;
      end
    end
    if (cmd.ch_step) begin
      chunk[{cbytes[2:0], 3'b000} +: 8] <= ch;
      cbytes <= cbytes + 4'd1;
      q      <= q + 8'd1;
      r      <= r - 8'd1;
    end
    if (cmd.ch_clear) begin
      chunk  <= '0;
      cbytes <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data         <= '0;
      out_data.kind    <= cmd.emit_kind;
      out_data.run_end <= cmd.emit_end;
      if (cmd.emit_kind == KIND_CHUNK) begin
        out_data.name_chunk  <= chunk;
        out_data.chunk_bytes <= cbytes;
      end else if (cmd.emit_kind == KIND_RECORD) begin
        out_data.entry_index  <= ecount[7:0];
        out_data.is_directory <= dir;
        out_data.entry_size   <= size;
        out_data.data_offset  <= offset;
        out_data.path_length  <= n;
      end else begin
        out_data.entries_total <= ecount;
      end
    end
  end

  always_comb begin
    status            = '0;
    status.hpos_last  = (hpos == HDR_LAST);
    status.bad_hdr    = (flen == 7'd0) || !magic_ok;
    status.scan_stop  = !((ch == CHAR_SLASH) && q_next_in) &&
                        !(!dot && ch == CHAR_DOT && q_next_in);
    status.n_zero     = (len == s);
    status.table_full = (ecount >= MaxEnt);
    status.chunk_done = (cbytes == 4'd7) || (r == 8'd1);
    status.r_zero     = (r == 8'd0);
    status.skip_one   = (skip == 37'd1);
    status.size_zero  = (size == '0);
    status.out_free   = !out_valid || out_ready;
    status.cbytes_nz  = (cbytes != 4'd0);
  end

endmodule

>>> rtl/taep_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taep_ctrl
// Controller: parse phases, path walk sequencing and result emission.
// ----------------------------------------------------------------------------
`include "tar_archive_entry_parser_top_macros.svh"

module taep_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_last,
  output logic                   in_ready,
  input  taep_pkg::taep_status_t status,
  output taep_pkg::taep_cmd_t    cmd
);
  import taep_pkg::*;

  taep_state_t st, st_next;
  logic        last_pend, last_next, accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_HEADER;
      last_pend <= 1'b0;
    end else begin
      st        <= st_next;
      last_pend <= last_next;
    end
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    st_next   = st;
    last_next = last_pend;
    in_ready  = 1'b0;
    unique case (st)
      ST_HEADER: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.any_byte = 1'b1;
          cmd.hdr_byte = 1'b1;
          if (status.hpos_last) begin
            st_next   = ST_EVAL;
            last_next = in_last;
          end else if (in_last) begin
            st_next = ST_FIN;
          end
        end
      end
      ST_SKIP: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.any_byte  = 1'b1;
          cmd.skip_byte = 1'b1;
          if (in_last) st_next = ST_FIN;
          else if (status.skip_one) st_next = ST_HEADER;
        end
      end
      ST_STOP: begin
        in_ready = 1'b1;
        if (accept) begin
          cmd.any_byte = 1'b1;
          if (in_last) st_next = ST_FIN;
        end
      end
      ST_EVAL: begin
        if (status.bad_hdr) begin
          st_next = last_pend ? ST_FIN : ST_STOP;
        end else begin
          cmd.eval_load = 1'b1;
          st_next       = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: st_next = ST_SCAN_CK;
      ST_SCAN_CK: begin
        cmd.scan_step = 1'b1;
        st_next       = status.scan_stop ? ST_DECIDE : ST_SCAN_RD;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        st_next    = (status.n_zero || status.table_full) ? ST_DONE : ST_LAST_RD;
      end
      ST_LAST_RD: st_next = ST_LAST_CK;
      ST_LAST_CK: begin
        cmd.last_chk = 1'b1;
        st_next      = ST_CH_RD;
      end
      ST_CH_RD: st_next = ST_CH_CK;
      ST_CH_CK: begin
        cmd.ch_step = 1'b1;
        st_next     = status.chunk_done ? ST_CH_OUT : ST_CH_RD;
      end
      ST_CH_OUT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_CHUNK;
          cmd.ch_clear  = 1'b1;
          st_next       = status.r_zero ? ST_REC : ST_CH_RD;
        end
      end
      ST_REC: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_RECORD;
          cmd.emit_end  = !last_pend;
          cmd.count_up  = 1'b1;
          st_next       = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.done = 1'b1;
        if (last_pend) st_next = ST_FIN;
        else st_next = status.size_zero ? ST_HEADER : ST_SKIP;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_kind = KIND_FINISHED;
          cmd.emit_end  = 1'b1;
          cmd.reset_all = 1'b1;
          last_next     = 1'b0;
          st_next       = ST_HEADER;
        end
      end
      default: st_next = ST_HEADER;
    endcase
  end

  `TAEP_ASSERT_NOW(a_emit_free, cmd.emit, status.out_free, "emit while output register busy")
  `TAEP_ASSERT_NEXT(a_fin_restart, st == ST_FIN && status.out_free, st == ST_HEADER && !last_pend, "finish did not restart parsing")
  `TAEP_ASSERT_NOW(a_chunk_nonempty, st == ST_CH_OUT, status.cbytes_nz, "empty name chunk pending")

endmodule

>>> rtl/tar_archive_entry_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tar_archive_entry_parser_top
// USTAR header parser emitting normalized entry names and entry records.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload
// in_item   in   byte_value, archive_end
// out_item  out  kind, name_chunk, chunk_bytes, entry_index, is_directory,
//                entry_size, data_offset, path_length, entries_total, run_end
//
// Header and data bytes are taken one per cycle, except while an entry is evaluated.
// After the last header byte, input is held during the leading "./" and "/" scan,
// the gathering of path characters and the emission of name chunks and the record;
// each character step has a read and a check state, as the name reads are registered.
// After a bad header, bytes go unparsed up to the final byte, which adds a finish item.
// Output stalls hold the controller in its emitting state.
// Reset is synchronous; the name stores need no clearing pass.
module tar_archive_entry_parser_top #(
  parameter int MAX_ENTRIES    = 256,
  parameter int PATH_MAX_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst,
  taep_chan_if.sink  in_item,
  taep_chan_if.source out_item
);
  import taep_pkg::*;

  taep_cmd_t    cmd;
  taep_status_t status;

  taep_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_item.valid),
    .in_last  (in_item.data.archive_end),
    .in_ready (in_item.ready),
    .status   (status),
    .cmd      (cmd)
  );

  taep_datapath #(
    .MAX_ENTRIES    (MAX_ENTRIES),
    .PATH_MAX_CHARS (PATH_MAX_CHARS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .byte_value (in_item.data.byte_value),
    .out_ready  (out_item.ready),
    .out_valid  (out_item.valid),
    .out_data   (out_item.data),
    .status     (status)
  );

endmodule
